### design/adpk_pkg.sv
// Shared types and constants for the periodic advection-diffusion step unit.
// Used by every module of the block except adpk_ram; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package adpk_pkg;

   // Store geometry and word widths.
   localparam int MAX_POINTS = 2048;
   localparam int IDX_W      = 11;
   localparam int CNT_W      = 12;
   localparam int WORD_W     = 32;
   localparam int COEF_W     = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int MIN_POINTS = 3;

   // Request codes, echoed back in the done kind.
   localparam logic [1:0] REQ_WRITE = 2'd0;
   localparam logic [1:0] REQ_STEP  = 2'd1;
   localparam logic [1:0] REQ_READ  = 2'd2;
   localparam logic [1:0] REQ_NONE  = 2'd3;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_DIFF  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ADV   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COUNT = 2'd2;

   // Configuration values after reset.
   localparam logic [COEF_W-1:0] DIFF_RESET  = 16'd3277;
   localparam logic [COEF_W-1:0] ADV_RESET   = 16'd66;
   localparam logic [CNT_W-1:0]  COUNT_RESET = 12'd1500;

   // Saturation limits of a signed Q16.16 word.
   localparam logic [WORD_W-1:0] WORD_MAX = 32'h7FFF_FFFF;
   localparam logic [WORD_W-1:0] WORD_MIN = 32'h8000_0000;

   // Tag that travels with each point through the stencil pipeline.
   typedef struct packed {
      logic             vld;
      logic             last;
      logic [IDX_W-1:0] idx;
   } sten_tag_type;

endpackage

`default_nettype wire

### design/periodic_advection_diffusion_step_unit.sv
// Top level of the periodic advection-diffusion step unit: request decode, sweep control,
// rod store, window cell chain and stencil pipeline. Depends on adpk_pkg and all adpk_ modules.
// Write, read and unknown requests answer in the cycle after acceptance, one word per cycle.
// A step request streams the store through one read port, one point per cycle, and answers
// after its last write-back (count clamped to 3..2048); busy stays high until
// its last write lands. Reset clears control state and restores the register defaults; the
// store is not cleared. The receiver cannot stall, so every result is shown for one cycle.
`timescale 1ns / 1ps
`default_nettype none

module periodic_advection_diffusion_step_unit
   import adpk_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire logic [1:0]            req_type,
   input  wire logic [IDX_W-1:0]      req_point_index,
   input  wire logic [WORD_W-1:0]     req_point_value,
   output logic                       rsp_valid,
   output logic      [WORD_W-1:0]     rsp_read_value,
   output logic      [1:0]            rsp_done_kind,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   typedef enum logic {
      ST_IDLE,
      ST_SWEEP
   } state_type;

   state_type         state_ff, state_in;
   logic [COEF_W-1:0] diff_ff, diff_in, adv_ff, adv_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  n_ff, n_in;
   logic              rd_run_ff, rd_run_in;
   logic [CNT_W-1:0]  rd_cnt_ff, rd_cnt_in;
   logic              rdv_ff;
   logic [CNT_W-1:0]  rdpos_ff;
   logic [WORD_W-1:0] first_old_ff, first_old_in;
   logic              win_new_ff;
   logic              win_last_ff;
   logic [IDX_W-1:0]  win_idx_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        rsp_kind_ff, rsp_kind_in;

   logic              accept, step_accept;
   logic [CNT_W-1:0]  n_plus1, sweep_addr_w, win_idx_w;
   logic [WORD_W-1:0] feed_data;
   logic              ram_we;
   logic [IDX_W-1:0]  ram_waddr, ram_raddr;
   logic [WORD_W-1:0] ram_wdata, ram_rdata;
   logic [WORD_W-1:0] cell_d [3];
   logic [WORD_W-1:0] cell_q [3];
   logic              cell_vd [3];
   logic              cell_v [3];
   sten_tag_type      sten_in_tag, sten_out_tag;
   logic [WORD_W-1:0] sten_value;

   // Request handshake.
   assign busy        = (state_ff == ST_SWEEP);
   assign accept      = start && !busy;
   assign step_accept = accept && (req_type == REQ_STEP);
   assign csr_ready   = 1'b1;

   // Configuration registers; an index beyond the list is ignored.
   always_comb begin
      diff_in  = diff_ff;
      adv_in   = adv_ff;
      count_in = count_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_DIFF:  diff_in  = csr_data;
            CSR_ADV:   adv_in   = csr_data;
            CSR_COUNT: count_in = csr_data[CNT_W-1:0];
            default:   ;
         endcase
      end
   end

   // Active ring length, saturated into the legal range.
   always_comb begin
      if (count_ff < CNT_W'(MIN_POINTS)) begin
         n_in = CNT_W'(MIN_POINTS);
      end else if (count_ff > CNT_W'(MAX_POINTS)) begin
         n_in = CNT_W'(MAX_POINTS);
      end else begin
         n_in = count_ff;
      end
   end

   // Read stream: ring end first, then every point, then one slot for the saved first word.
   assign n_plus1 = n_ff + 1'b1;

   always_comb begin
      rd_run_in = rd_run_ff;
      rd_cnt_in = rd_cnt_ff;
      if (step_accept) begin
         rd_run_in = 1'b1;
         rd_cnt_in = '0;
      end else if (rd_run_ff) begin
         rd_cnt_in = rd_cnt_ff + 1'b1;
         if (rd_cnt_ff == n_plus1) begin
            rd_run_in = 1'b0;
         end
      end
   end

   assign sweep_addr_w = (rd_cnt_ff == '0) ? (n_ff - 1'b1) : (rd_cnt_ff - 1'b1);

   // The old first word is kept aside, as the store copy is overwritten before the ring closes.
   assign feed_data = (rdpos_ff == n_plus1) ? first_old_ff : ram_rdata;
   assign first_old_in = (rdv_ff && rdpos_ff == CNT_W'(1)) ? ram_rdata : first_old_ff;
   assign win_idx_w = rdpos_ff - CNT_W'(2);

   // State machine, sweep control and the registered result word.
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = 1'b0;
      rsp_kind_in  = rsp_kind_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_kind_in = req_type;
               if (req_type == REQ_STEP) begin
                  state_in = ST_SWEEP;
               end else begin
                  rsp_valid_in = 1'b1;
               end
            end
         end
         ST_SWEEP: begin
            if (sten_out_tag.vld && sten_out_tag.last) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_kind_in  = REQ_STEP;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         diff_ff      <= DIFF_RESET;
         adv_ff       <= ADV_RESET;
         count_ff     <= COUNT_RESET;
         rd_run_ff    <= 1'b0;
         rd_cnt_ff    <= '0;
         rdv_ff       <= 1'b0;
         win_new_ff   <= 1'b0;
         first_old_ff <= '0;
         rsp_valid_ff <= 1'b0;
         rsp_kind_ff  <= REQ_WRITE;
      end else begin
         state_ff     <= state_in;
         diff_ff      <= diff_in;
         adv_ff       <= adv_in;
         count_ff     <= count_in;
         rd_run_ff    <= rd_run_in;
         rd_cnt_ff    <= rd_cnt_in;
         rdv_ff       <= rd_run_ff;
         win_new_ff   <= rdv_ff;
         first_old_ff <= first_old_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_kind_ff  <= rsp_kind_in;
      end
   end

   // Payload registers of the sweep.
   always_ff @(posedge clock) begin
      if (step_accept) begin
         n_ff <= n_in;
      end
      rdpos_ff    <= rd_cnt_ff;
      win_idx_ff  <= win_idx_w[IDX_W-1:0];
      win_last_ff <= (rdpos_ff == n_plus1);
   end

   // Rod store, shared by single-point requests and the sweep.
   always_comb begin
      if (sten_out_tag.vld) begin
         ram_we    = 1'b1;
         ram_waddr = sten_out_tag.idx;
         ram_wdata = sten_value;
      end else begin
         ram_we    = accept && (req_type == REQ_WRITE);
         ram_waddr = req_point_index;
         ram_wdata = req_point_value;
      end
      ram_raddr = busy ? sweep_addr_w[IDX_W-1:0] : req_point_index;
   end

   adpk_ram #(
      .WIDTH (WORD_W),
      .DEPTH (MAX_POINTS)
   ) u_rod_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // Window chain: cell 0 takes the stream, cell 1 holds the centre, cell 2 the left neighbour.
   assign cell_d[0]  = feed_data;
   assign cell_vd[0] = 1'b1;

   for (genvar k = 0; k < 3; k++) begin : g_cell
      if (k > 0) begin : g_link
         assign cell_d[k]  = cell_q[k-1];
         assign cell_vd[k] = cell_v[k-1];
      end
      adpk_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .clear    (step_accept),
         .shift_en (rdv_ff),
         .d_in     (cell_d[k]),
         .v_in     (cell_vd[k]),
         .q        (cell_q[k]),
         .v_q      (cell_v[k])
      );
   end

   // A point enters the stencil once the window has shifted and all three cells are full.
   always_comb begin
      sten_in_tag.vld  = win_new_ff && cell_v[0] && cell_v[1] && cell_v[2];
      sten_in_tag.last = win_last_ff;
      sten_in_tag.idx  = win_idx_ff;
   end

   adpk_stencil u_stencil (
      .clock      (clock),
      .reset      (reset),
      .tag_in     (sten_in_tag),
      .left       (cell_q[2]),
      .mid        (cell_q[1]),
      .right      (cell_q[0]),
      .diff_coeff (diff_ff),
      .adv_coeff  (adv_ff),
      .tag_out    (sten_out_tag),
      .new_value  (sten_value)
   );

   // Result word; only a read carries data, from the store's registered read.
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_done_kind  = rsp_kind_ff;
   assign rsp_read_value = (rsp_valid_ff && rsp_kind_ff == REQ_READ) ? ram_rdata : '0;

   // Sweep write-backs only happen while a step is in progress.
   a_write_in_sweep: assert property (@(posedge clock) disable iff (reset)
      sten_out_tag.vld |-> (state_ff == ST_SWEEP))
      else $error("stencil write-back outside a sweep");

   // Every write-back stays inside the active ring.
   a_write_in_ring: assert property (@(posedge clock) disable iff (reset)
      sten_out_tag.vld |-> ({1'b0, sten_out_tag.idx} < n_ff))
      else $error("stencil write-back beyond the active ring");

   // The last write-back of a step releases the block in the next cycle.
   a_release_after_last: assert property (@(posedge clock) disable iff (reset)
      (sten_out_tag.vld && sten_out_tag.last) |=> !busy)
      else $error("block still busy after the last write-back");

   // A single-point result always follows an accepted request in the previous cycle.
   a_single_rsp_origin: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_kind_ff != REQ_STEP) |-> $past(start && !busy))
      else $error("single-point result without an accepted request");

   // An accepted step starts the read stream.
   a_step_starts_stream: assert property (@(posedge clock) disable iff (reset)
      step_accept |=> rd_run_ff)
      else $error("step accepted but no read stream started");

endmodule

`default_nettype wire

### design/adpk_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Self-contained; no package needed.
`timescale 1ns / 1ps
`default_nettype none

module adpk_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 2048
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write and registered read in the same clocked block.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

### design/adpk_cell.sv
// One cell of the stencil window chain: holds one old word and its valid flag.
// Depends on adpk_pkg for the word width.
`timescale 1ns / 1ps
`default_nettype none

module adpk_cell
   import adpk_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              clear,
   input  wire logic              shift_en,
   input  wire logic [WORD_W-1:0] d_in,
   input  wire logic              v_in,
   output logic      [WORD_W-1:0] q,
   output logic                   v_q
);

   logic [WORD_W-1:0] val_ff, val_in;
   logic              vld_ff, vld_in;

   // Take the neighbour's word on a shift; the flag empties at sweep start.
   always_comb begin
      val_in = shift_en ? d_in : val_ff;
      if (clear) begin
         vld_in = 1'b0;
      end else if (shift_en) begin
         vld_in = v_in;
      end else begin
         vld_in = vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign q   = val_ff;
   assign v_q = vld_ff;

endmodule

`default_nettype wire

### design/adpk_stencil.sv
// Three-stage stencil pipeline: differences, coefficient products, sum and saturation.
// Depends on adpk_pkg for widths, limits and the point tag type.
`timescale 1ns / 1ps
`default_nettype none

module adpk_stencil
   import adpk_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire sten_tag_type      tag_in,
   input  wire logic [WORD_W-1:0] left,
   input  wire logic [WORD_W-1:0] mid,
   input  wire logic [WORD_W-1:0] right,
   input  wire logic [COEF_W-1:0] diff_coeff,
   input  wire logic [COEF_W-1:0] adv_coeff,
   output sten_tag_type           tag_out,
   output logic      [WORD_W-1:0] new_value
);

   sten_tag_type       s1_tag_ff, s2_tag_ff, s3_tag_ff;
   logic signed [33:0] lap_ff, lap_in;
   logic signed [32:0] grad_ff, grad_in;
   logic [WORD_W-1:0]  mid1_ff, mid2_ff;
   logic signed [50:0] dprod_ff, dprod_in;
   logic signed [49:0] aprod_ff, aprod_in;
   logic signed [37:0] dterm, aterm, sum;
   logic [WORD_W-1:0]  val_ff, val_in;

   // Stage one: Laplacian and central difference, exact at full width.
   always_comb begin
      lap_in  = 34'($signed(right)) + 34'($signed(left)) - (34'($signed(mid)) <<< 1);
      grad_in = 33'($signed(right)) - 33'($signed(left));
   end

   // Stage two: one product per coefficient, both unsigned Q0.16.
   always_comb begin
      dprod_in = 51'($signed({1'b0, diff_coeff})) * 51'(lap_ff);
      aprod_in = 50'($signed({1'b0, adv_coeff})) * 50'(grad_ff);
   end

   // Stage three: floor shift of both products, sum and saturate to 32 bits.
   always_comb begin
      dterm = {{3{dprod_ff[50]}}, dprod_ff[50:16]};
      aterm = {{4{aprod_ff[49]}}, aprod_ff[49:16]};
      sum   = {{6{mid2_ff[WORD_W-1]}}, mid2_ff} + dterm - aterm;
      if (sum[37:31] == 7'b0000000 || sum[37:31] == 7'b1111111) begin
         val_in = sum[WORD_W-1:0];
      end else if (sum[37]) begin
         val_in = WORD_MIN;
      end else begin
         val_in = WORD_MAX;
      end
   end

   // Pipeline payload registers.
   always_ff @(posedge clock) begin
      lap_ff   <= lap_in;
      grad_ff  <= grad_in;
      mid1_ff  <= mid;
      dprod_ff <= dprod_in;
      aprod_ff <= aprod_in;
      mid2_ff  <= mid1_ff;
      val_ff   <= val_in;
   end

   // Pipeline tags, cleared by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_tag_ff <= '0;
         s2_tag_ff <= '0;
         s3_tag_ff <= '0;
      end else begin
         s1_tag_ff <= tag_in;
         s2_tag_ff <= s1_tag_ff;
         s3_tag_ff <= s2_tag_ff;
      end
   end

   assign tag_out   = s3_tag_ff;
   assign new_value = val_ff;

endmodule

`default_nettype wire

### test/periodic_advection_diffusion_step_unit_tb.sv
// Self-checking bench for periodic_advection_diffusion_step_unit: writes, reads and time steps
// on the periodic rod, checked word by word against an in-bench fixed-point sweep.
// Depends on adpk_pkg and the design top level only.
`timescale 1ns / 1ps

module periodic_advection_diffusion_step_unit_tb;
   import adpk_pkg::*;

   localparam int QUIET_LIMIT = 20000;
   localparam longint Q_TOP = 64'sh0000_0000_7FFF_FFFF;
   localparam longint Q_BOT = -64'sh0000_0000_8000_0000;
   localparam int RANDOM_OPS = 180;
   localparam int PHASE_OPS  = 30;

   typedef struct packed {
      logic [1:0]        kind;
      logic [IDX_W-1:0]  idx;
      logic [WORD_W-1:0] val;
   } rod_cmd_type;

   typedef struct packed {
      logic [WORD_W-1:0] value;
      logic [1:0]        kind;
   } rod_answer_type;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic [1:0]            req_type;
   logic [IDX_W-1:0]      req_point_index;
   logic [WORD_W-1:0]     req_point_value;
   logic                  rsp_valid;
   logic [WORD_W-1:0]     rsp_read_value;
   logic [1:0]            rsp_done_kind;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   // Bench-side copy of the rod and its registers.
   logic [WORD_W-1:0] rod_img [MAX_POINTS];
   logic [COEF_W-1:0] k_diff;
   logic [COEF_W-1:0] c_adv;
   logic [CNT_W-1:0]  count_reg;

   // Stimulus bookkeeping: points that have a write queued, pending commands, due answers.
   bit             filled [MAX_POINTS];
   rod_cmd_type    cmd_q [$];
   rod_answer_type due_answers [$];

   logic req_taken = 1'b0;
   logic csr_taken = 1'b0;
   logic calm = 1'b0;
   int   gap_left = 0;
   int   quiet_cycles = 0;
   int   mismatches = 0;
   int   mixed_items = 0;

   periodic_advection_diffusion_step_unit u_top (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_type        (req_type),
      .req_point_index (req_point_index),
      .req_point_value (req_point_value),
      .rsp_valid       (rsp_valid),
      .rsp_read_value  (rsp_read_value),
      .rsp_done_kind   (rsp_done_kind),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // The active ring length is the raw count clamped into the legal range.
   function automatic int ring_len(input logic [CNT_W-1:0] raw);
      if (raw < MIN_POINTS) return MIN_POINTS;
      if (raw > MAX_POINTS) return MAX_POINTS;
      return int'(raw);
   endfunction

   // One in-place sweep over the ring, keeping the old values of point 0 and of the point just behind.
   function automatic void advance_rod();
      int     n;
      longint head, behind, mid, lft, rgt, lap, grad, nv;
      n = ring_len(count_reg);
      head = longint'(signed'(rod_img[0]));
      behind = 0;
      for (int i = 0; i < n; i++) begin
         mid  = longint'(signed'(rod_img[i]));
         lft  = (i == 0) ? longint'(signed'(rod_img[n - 1])) : behind;
         rgt  = (i == n - 1) ? head : longint'(signed'(rod_img[i + 1]));
         lap  = rgt + lft - 2 * mid;
         grad = rgt - lft;
         // Arithmetic shift of a signed product rounds towards minus infinity.
         nv = mid + ((longint'(k_diff) * lap) >>> 16) - ((longint'(c_adv) * grad) >>> 16);
         behind = mid;
         if (nv > Q_TOP)
            rod_img[i] = WORD_MAX;
         else if (nv < Q_BOT)
            rod_img[i] = WORD_MIN;
         else
            rod_img[i] = nv[WORD_W-1:0];
      end
   endfunction

   // Every request answers once; only a read carries a value.
   function automatic rod_answer_type apply_request(input logic [1:0] kind,
                                                    input logic [IDX_W-1:0] idx,
                                                    input logic [WORD_W-1:0] val);
      rod_answer_type ans;
      ans.kind  = kind;
      ans.value = '0;
      case (kind)
         REQ_WRITE: rod_img[idx] = val;
         REQ_STEP:  advance_rod();
         REQ_READ:  ans.value = rod_img[idx];
         default: ;
      endcase
      return ans;
   endfunction

   // Temperatures: the extremes, zero, moderate values and full-range noise.
   function automatic logic [WORD_W-1:0] pick_temp();
      logic [WORD_W-1:0] raw;
      raw = $urandom();
      case ($urandom_range(0, 9))
         0: return WORD_MAX;
         1: return WORD_MIN;
         2: return '0;
         3, 4, 5: return {{8{raw[23]}}, raw[23:0]};
         default: return raw;
      endcase
   endfunction

   function automatic logic [COEF_W-1:0] pick_coef();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return 16'hFFFF;
         2, 3: return COEF_W'($urandom_range(0, 4000));
         default: return COEF_W'($urandom());
      endcase
   endfunction

   task automatic post(input logic [1:0] kind, input int idx, input logic [WORD_W-1:0] val);
      rod_cmd_type c;
      c.kind = kind;
      c.idx  = idx[IDX_W-1:0];
      c.val  = val;
      cmd_q.push_back(c);
      if (kind == REQ_WRITE) filled[idx] = 1'b1;
   endtask

   // Writes all three registers in turn, one word per handshake; starts and ends on a falling edge.
   task automatic program_regs(input logic [COEF_W-1:0] d, input logic [COEF_W-1:0] a,
                               input logic [CSR_DATA_W-1:0] cnt);
      logic [CSR_DATA_W-1:0] word_val [3];
      logic [CSR_IDX_W-1:0]  reg_sel [3];
      word_val = '{d, a, cnt};
      reg_sel  = '{CSR_DIFF, CSR_ADV, CSR_COUNT};
      for (int r = 0; r < 3; r++) begin
         csr_valid <= 1'b1;
         csr_index <= reg_sel[r];
         csr_data  <= word_val[r];
         do @(negedge clock); while (!csr_taken);
      end
      csr_valid <= 1'b0;
   endtask

   // Waits until every command has gone in and been answered, then lets the sweep finish.
   task automatic settle(input int tail);
      while (cmd_q.size() != 0 || start || due_answers.size() != 0) @(negedge clock);
      repeat (tail) @(negedge clock);
      while (busy) @(negedge clock);
   endtask

   // Every active point must hold a written value before a step sweeps over it.
   task automatic fill_ring(input int n);
      for (int i = 0; i < n; i++) begin
         if (!filled[i] || (n <= 64 && $urandom_range(0, 1) == 1))
            post(REQ_WRITE, i, pick_temp());
      end
   endtask

   // Mixed traffic on a filled ring: steps, reads of written points, writes and unknown codes.
   task automatic mix_ops(input int n, input int ops);
      int r, idx;
      for (int j = 0; j < ops; j++) begin
         r = $urandom_range(0, 99);
         if (r < 18) begin
            post(REQ_STEP, $urandom_range(0, MAX_POINTS - 1), $urandom());
         end else if (r < 50) begin
            idx = $urandom_range(0, MAX_POINTS - 1);
            if (!filled[idx] || $urandom_range(0, 2) != 0) idx = $urandom_range(0, n - 1);
            post(REQ_READ, idx, $urandom());
         end else if (r < 85) begin
            // Some writes land beyond the ring, where steps never reach.
            if ($urandom_range(0, 9) < 7)
               idx = $urandom_range(0, n - 1);
            else
               idx = $urandom_range(0, MAX_POINTS - 1);
            post(REQ_WRITE, idx, pick_temp());
         end else begin
            post(REQ_NONE, $urandom_range(0, MAX_POINTS - 1), $urandom());
         end
      end
      mixed_items += ops;
   endtask

   // Request driver: holds a word until it is taken, with random idle bursts between words.
   always @(negedge clock) begin : drive
      rod_cmd_type nxt;
      if (reset) begin
         start <= 1'b0;
      end else if (!start || req_taken) begin
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            start    <= 1'b0;
         end else if (cmd_q.size() != 0 && !calm && $urandom_range(0, 5) == 0) begin
            gap_left <= $urandom_range(0, 18);
            start    <= 1'b0;
         end else if (cmd_q.size() != 0) begin
            nxt = cmd_q.pop_front();
            start           <= 1'b1;
            req_type        <= nxt.kind;
            req_point_index <= nxt.idx;
            req_point_value <= nxt.val;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor: checks answers, predicts each accepted request, tracks register writes.
   always @(posedge clock) begin : observe
      rod_answer_type want;
      if (reset) begin
         k_diff    = DIFF_RESET;
         c_adv     = ADV_RESET;
         count_reg = COUNT_RESET;
         req_taken = 1'b0;
         csr_taken = 1'b0;
      end else begin
         if (rsp_valid) begin
            if (due_answers.size() == 0) begin
               $error("unexpected answer: read_value %h done_kind %0d",
                      rsp_read_value, rsp_done_kind);
               mismatches++;
            end else begin
               want = due_answers.pop_front();
               if (rsp_read_value !== want.value) begin
                  $error("read_value: expected %h, got %h", want.value, rsp_read_value);
                  mismatches++;
               end
               if (rsp_done_kind !== want.kind) begin
                  $error("done_kind: expected %0d, got %0d", want.kind, rsp_done_kind);
                  mismatches++;
               end
            end
         end
         req_taken = start && !busy;
         if (req_taken)
            due_answers.push_back(apply_request(req_type, req_point_index, req_point_value));
         csr_taken = csr_valid && csr_ready;
         if (csr_taken) begin
            case (csr_index)
               CSR_DIFF:  k_diff = csr_data;
               CSR_ADV:   c_adv = csr_data;
               CSR_COUNT: count_reg = csr_data[CNT_W-1:0];
               default: ;
            endcase
         end
      end
      // Watchdog on cycles with no word moving on any channel.
      if (req_taken || csr_taken || rsp_valid === 1'b1)
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("periodic_advection_diffusion_step_unit_tb: errors");
         $finish;
      end
   end

   // Stimulus sequence.
   initial begin : stimulus
      logic [CNT_W-1:0] raw;
      int               phase;
      reset           = 1'b1;
      start           = 1'b0;
      req_type        = REQ_WRITE;
      req_point_index = '0;
      req_point_value = '0;
      csr_valid       = 1'b0;
      csr_index       = CSR_DIFF;
      csr_data        = '0;
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Default registers: store extremes, a point beyond the ring, unknown codes.
      post(REQ_WRITE, 0, WORD_MAX);
      post(REQ_WRITE, MAX_POINTS - 1, WORD_MIN);
      post(REQ_WRITE, 1500, 32'h0001_0000);
      post(REQ_READ, 0, '0);
      post(REQ_READ, MAX_POINTS - 1, '0);
      post(REQ_READ, 1500, '1);
      post(REQ_NONE, MAX_POINTS - 1, '1);
      post(REQ_NONE, 0, '0);
      settle(16);

      // Full-scale coefficients on a three-point ring (count 0 clamps up) to force saturation.
      program_regs(16'hFFFF, 16'hFFFF, 16'h0000);
      @(posedge clock);
      post(REQ_WRITE, 0, WORD_MAX);
      post(REQ_WRITE, 1, WORD_MIN);
      post(REQ_WRITE, 2, WORD_MAX);
      post(REQ_STEP, 0, '0);
      post(REQ_READ, 0, '0);
      post(REQ_READ, 1, '0);
      post(REQ_READ, 2, '0);
      post(REQ_STEP, MAX_POINTS - 1, '1);
      post(REQ_READ, 1, '0);
      settle(16);

      // Zero coefficients leave the ring unchanged; count 2 with stray upper bits clamps to 3.
      program_regs(16'h0000, 16'h0000, 16'hF002);
      @(posedge clock);
      post(REQ_WRITE, 0, 32'h0001_8000);
      post(REQ_WRITE, 1, 32'hFFFE_0000);
      post(REQ_WRITE, 2, '0);
      post(REQ_STEP, 0, '0);
      post(REQ_READ, 0, '0);
      post(REQ_READ, 1, '0);
      post(REQ_READ, 2, '0);
      settle(16);

      // Random phases: fresh registers, a filled ring, then mixed traffic.
      phase = 0;
      while (mixed_items < RANDOM_OPS) begin
         case (phase)
            0: raw = 12'd3;
            1: raw = 12'd1;
            default: begin
               if ($urandom_range(0, 9) == 0)
                  raw = CNT_W'($urandom_range(0, 2));
               else
                  raw = CNT_W'($urandom_range(3, 48));
            end
         endcase
         program_regs(pick_coef(), pick_coef(), {4'($urandom_range(0, 15)), raw});
         @(posedge clock);
         if (mixed_items + PHASE_OPS >= RANDOM_OPS) calm = 1'b1;
         fill_ring(ring_len(raw));
         mix_ops(ring_len(raw), PHASE_OPS);
         settle(16);
         phase++;
      end

      settle(32);
      if (mismatches == 0)
         $display("periodic_advection_diffusion_step_unit_tb: clean");
      else
         $display("periodic_advection_diffusion_step_unit_tb: errors");
      $finish;
   end

endmodule
